// ===== design/multi_channel_ramp_generator_defines.svh =====
// assertion macros shared by the ramp generator modules
`ifndef MULTI_CHANNEL_RAMP_GENERATOR_DEFINES_SVH
`define MULTI_CHANNEL_RAMP_GENERATOR_DEFINES_SVH

// condition must hold at every clock edge outside reset
`define MCRG_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define MCRG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MCRG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/mcrg_pkg.sv =====
// types and constants of the multi-channel ramp generator
package mcrg_pkg;

   localparam int LevelWidth          = 16;
   localparam int NumChannelsDefault  = 2;

   // request kinds
   localparam logic ReqTick  = 1'b0;
   localparam logic ReqStart = 1'b1;

   typedef struct packed {
      logic                  req_type;
      logic                  channel;
      logic [LevelWidth-1:0] target;
      logic [LevelWidth-1:0] speed;
   } req_item_type;

   typedef struct packed {
      logic                  out_channel;
      logic [LevelWidth-1:0] level;
      logic                  last;
   } rsp_item_type;

   // one channel's stored state
   typedef struct packed {
      logic [LevelWidth-1:0] level;
      logic [LevelWidth-1:0] target;
      logic [LevelWidth-1:0] step;
      logic                  rising;
   } chan_entry_type;

   typedef struct packed {
      logic [LevelWidth-1:0] dividend;
      logic [LevelWidth-1:0] divisor;
   } div_req_type;

endpackage

// ===== design/mcrg_store.sv =====
// channel state memory with per-entry valid bits and a registered read port
`include "multi_channel_ramp_generator_defines.svh"

module mcrg_store #(
   parameter int Depth = mcrg_pkg::NumChannelsDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rd_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
   output mcrg_pkg::chan_entry_type          rd_data,
   input  logic                              wr_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  mcrg_pkg::chan_entry_type          wr_data
);

   mcrg_pkg::chan_entry_type mem_ff [Depth];
   logic [Depth-1:0]         valid_ff;
   mcrg_pkg::chan_entry_type rd_data_ff;
   logic                     rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // entries never written read as the reset value of zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

   `MCRG_ASSERT_SAME(a_no_rw_same_entry, clock, reset, wr_en && rd_en, wr_addr != rd_addr, "read and write hit the same entry")

endmodule

// ===== design/mcrg_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`include "multi_channel_ramp_generator_defines.svh"

module mcrg_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  mcrg_pkg::div_req_type               req,
   output logic                                done,
   output logic [mcrg_pkg::LevelWidth-1:0]     quotient
);

   localparam int Width    = mcrg_pkg::LevelWidth;
   localparam int CntWidth = $clog2(Width);

   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic [Width-1:0]    rem_ff, rem_in;
   logic [Width-1:0]    quo_ff, quo_in;
   logic [Width-1:0]    dvs_ff, dvs_in;
   logic [Width:0]      shifted;
   logic [Width:0]      trial;

   assign shifted = {rem_ff, quo_ff[Width-1]};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = req.dividend;
         dvs_in = req.divisor;
      end else if (run_ff) begin
         if (!trial[Width]) begin
            rem_in = trial[Width-1:0];
            quo_in = {quo_ff[Width-2:0], 1'b1};
         end else begin
            rem_in = shifted[Width-1:0];
            quo_in = {quo_ff[Width-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntWidth'(Width - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   `MCRG_ASSERT_SAME(a_no_restart, clock, reset, start, !run_ff, "divider started while running")

endmodule

// ===== design/multi_channel_ramp_generator.sv =====
// Multi-channel ramp generator. Items are taken when start is high and busy is low; one item
// is worked at a time. A start item that loads a new ramp does one memory read, then the
// 16-step serial divider that forms speed / distance, then the write-back; when the target
// already equals the level it ends after the read. For a tick item the channel state memory
// is read one channel per cycle and each moving channel written back. Each moved channel
// gives one result on rsp_item, strobed by rsp_strobe for exactly one cycle, in ascending
// channel order, the final one with last set; the receiver cannot stall results, and the last
// result of a tick appears in the same cycle as busy falls. A tick with no channel to move
// gives no result. No clearing pass is needed after reset.
`include "multi_channel_ramp_generator_defines.svh"

module multi_channel_ramp_generator #(
   parameter int NUM_CHANNELS = mcrg_pkg::NumChannelsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  mcrg_pkg::req_item_type req_item,
   output logic                   rsp_strobe,
   output mcrg_pkg::rsp_item_type rsp_item
);

   localparam int Width     = mcrg_pkg::LevelWidth;
   localparam int AddrWidth = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START_RD,
      ST_START_DIV,
      ST_TICK_RD,
      ST_TICK_END
   } state_type;

   state_type                state_ff, state_in;
   mcrg_pkg::req_item_type   req_ff, req_in;
   logic [AddrWidth-1:0]     chan_ff, chan_in;
   mcrg_pkg::chan_entry_type entry_ff, entry_in;
   logic                     pend_valid_ff, pend_valid_in;
   mcrg_pkg::rsp_item_type   pend_item_ff, pend_item_in;
   logic                     rsp_strobe_ff, rsp_strobe_in;
   mcrg_pkg::rsp_item_type   rsp_item_ff, rsp_item_in;

   logic                     rd_en;
   logic [AddrWidth-1:0]     rd_addr;
   mcrg_pkg::chan_entry_type rd_data;
   logic                     wr_en;
   logic [AddrWidth-1:0]     wr_addr;
   mcrg_pkg::chan_entry_type wr_data;

   logic                     div_start;
   mcrg_pkg::div_req_type    div_req;
   logic                     div_done;
   logic [Width-1:0]         div_quotient;

   logic                     chan_ok;
   logic                     moving;
   logic [Width:0]           sum;
   logic [Width:0]           diff;
   logic [Width-1:0]         new_level;
   logic                     at_last_chan;

   mcrg_store #(
      .Depth (NUM_CHANNELS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   mcrg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign chan_ok = (32'(req_item.channel) < NUM_CHANNELS);

   // step with clamp, worked at 17 bits so a wrap cannot jump past the target
   assign moving = (rd_data.level != rd_data.target);
   assign sum    = {1'b0, rd_data.level} + {1'b0, rd_data.step};
   assign diff   = {1'b0, rd_data.level} - {1'b0, rd_data.step};

   always_comb begin
      if (rd_data.rising) begin
         new_level = (sum >= {1'b0, rd_data.target}) ? rd_data.target : sum[Width-1:0];
      end else begin
         new_level = ($signed(diff) <= $signed({1'b0, rd_data.target})) ?
                     rd_data.target : diff[Width-1:0];
      end
   end

   assign at_last_chan = (chan_ff == AddrWidth'(NUM_CHANNELS - 1));

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      chan_in       = chan_ff;
      entry_in      = entry_ff;
      pend_valid_in = pend_valid_ff;
      pend_item_in  = pend_item_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      rd_en         = 1'b0;
      rd_addr       = chan_ff;
      wr_en         = 1'b0;
      wr_addr       = chan_ff;
      wr_data       = rd_data;
      div_start     = 1'b0;
      div_req.dividend = req_ff.speed;
      div_req.divisor  = rd_data.level - req_ff.target;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_item;
               if (req_item.req_type == mcrg_pkg::ReqTick) begin
                  rd_en         = 1'b1;
                  rd_addr       = '0;
                  chan_in       = '0;
                  pend_valid_in = 1'b0;
                  state_in      = ST_TICK_RD;
               end else if (chan_ok) begin
                  rd_en    = 1'b1;
                  rd_addr  = AddrWidth'(req_item.channel);
                  chan_in  = AddrWidth'(req_item.channel);
                  state_in = ST_START_RD;
               end
            end
         end
         ST_START_RD: begin
            if (req_ff.target == rd_data.level) begin
               state_in = ST_IDLE;
            end else begin
               entry_in.level  = rd_data.level;
               entry_in.target = req_ff.target;
               entry_in.step   = '0;
               entry_in.rising = (rd_data.level < req_ff.target);
               if (rd_data.level < req_ff.target) begin
                  div_req.divisor = req_ff.target - rd_data.level;
               end
               div_start = 1'b1;
               state_in  = ST_START_DIV;
            end
         end
         ST_START_DIV: begin
            if (div_done) begin
               wr_en        = 1'b1;
               wr_data      = entry_ff;
               wr_data.step = div_quotient;
               state_in     = ST_IDLE;
            end
         end
         ST_TICK_RD: begin
            if (moving) begin
               wr_en         = 1'b1;
               wr_data.level = new_level;
               // hold each result back until the next moved channel to know whether it is the last
               if (pend_valid_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_item_in   = pend_item_ff;
               end
               pend_valid_in            = 1'b1;
               pend_item_in.out_channel = chan_ff[0];
               pend_item_in.level       = new_level;
               pend_item_in.last        = 1'b0;
            end
            if (at_last_chan) begin
               state_in = ST_TICK_END;
            end else begin
               chan_in  = chan_ff + 1'b1;
               rd_en    = 1'b1;
               rd_addr  = chan_ff + 1'b1;
            end
         end
         ST_TICK_END: begin
            if (pend_valid_ff) begin
               rsp_strobe_in    = 1'b1;
               rsp_item_in      = pend_item_ff;
               rsp_item_in.last = 1'b1;
            end
            pend_valid_in = 1'b0;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff       <= req_in;
      chan_ff      <= chan_in;
      entry_ff     <= entry_in;
      pend_item_ff <= pend_item_in;
      rsp_item_ff  <= rsp_item_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   `MCRG_ASSERT_NEXT(a_last_closes_tick, clock, reset, rsp_strobe && rsp_item.last, !rsp_strobe, "result follows the last of a tick")
   `MCRG_ASSERT_SAME(a_more_follow, clock, reset, rsp_strobe && !rsp_item.last, busy, "non-final result with tick already finished")
   `MCRG_ASSERT_NEXT(a_tick_busy, clock, reset, start && !busy && (req_item.req_type == mcrg_pkg::ReqTick), busy, "tick item not taken up")
   `MCRG_ASSERT_SAME(a_write_in_work, clock, reset, wr_en, (state_ff == ST_START_DIV) || (state_ff == ST_TICK_RD), "state write outside an update step")

endmodule
